// File: design/fpa_pkg.sv
package fpa_pkg;

  localparam int WORD_W    = 32;
  localparam int DIV_STEPS = 32;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_MIN      = 4'd4,
    CMD_MAX      = 4'd5,
    CMD_INC      = 4'd6,
    CMD_DEC      = 4'd7,
    CMD_TO_INT   = 4'd8,
    CMD_FROM_INT = 4'd9
  } cmd_t;

  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               a_greater;
    logic               a_less;
    logic               a_greater_equal;
    logic               a_less_equal;
    logic               a_equal;
    logic               a_not_equal;
    logic               divide_by_zero;
    logic               saturated;
  } alu_rsp_t;

  typedef struct packed {
    logic gt;
    logic lt;
    logic ge;
    logic le;
    logic eq;
    logic ne;
  } cmp_flags_t;

  // record carried through the divider chain
  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] res;
    logic        sat;
    logic        dbz;
    cmp_flags_t  cmp;
    logic [31:0] rem;
    logic [31:0] den;
    logic [31:0] low;
    logic [31:0] quo;
    logic        neg;
    logic        ovf;
  } div_rec_t;

  // apply sign to a magnitude, clamp to a word; returns {sat, word}
  function automatic logic [32:0] sign_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, WORD_MIN};
      else                     r = {1'b0, 32'(64'd0 - mag)};
    end else begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, WORD_MAX};
      else                     r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

endpackage

// File: design/fpa_front.sv
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  fpa_pkg::alu_req_t in_req,
  output logic              out_valid,
  output fpa_pkg::div_rec_t out_rec
);
  import fpa_pkg::*;

  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  // stage 1
  logic        v1;
  logic [3:0]  cmd1;
  logic signed [31:0] a1, b1;
  logic [31:0] res1;
  logic        sat1;
  cmp_flags_t  cmp1;
  logic [31:0] maga1, magb1;
  logic        neg1;

  // stage 2
  logic        v2;
  logic [3:0]  cmd2;
  logic [31:0] res2;
  logic        sat2;
  cmp_flags_t  cmp2;
  logic signed [63:0] prod2;
  logic [63:0] num2;
  logic [31:0] den2;
  logic        neg2, ovf2, bz2;

  // stage 3
  logic        v3;
  logic [3:0]  cmd3;
  logic [31:0] res3;
  logic        sat3;
  cmp_flags_t  cmp3;
  logic [63:0] pmag3;
  logic        pneg3;
  logic [63:0] num3;
  logic [31:0] den3;
  logic        neg3, ovf3, bz3;

  // stage 4
  logic        v4;
  logic [3:0]  cmd4;
  logic [31:0] res4;
  logic        sat4;
  cmp_flags_t  cmp4;
  logic [63:0] m4;
  logic        pneg4;
  logic [63:0] num4;
  logic [31:0] den4;
  logic        neg4, ovf4, bz4;

  logic signed [32:0] sum, diff;
  logic [31:0] res_s;
  logic        sat_s;
  cmp_flags_t  cmp_s;
  logic [32:0] smag;

  always_comb begin
    sum  = 33'(in_req.operand_a) + 33'(in_req.operand_b);
    diff = 33'(in_req.operand_a) - 33'(in_req.operand_b);
    cmp_s.gt = in_req.operand_a >  in_req.operand_b;
    cmp_s.lt = in_req.operand_a <  in_req.operand_b;
    cmp_s.ge = in_req.operand_a >= in_req.operand_b;
    cmp_s.le = in_req.operand_a <= in_req.operand_b;
    cmp_s.eq = in_req.operand_a == in_req.operand_b;
    cmp_s.ne = in_req.operand_a != in_req.operand_b;
    res_s = '0;
    sat_s = 1'b0;
    unique case (in_req.cmd)
      CMD_ADD: begin
        if (sum[32] != sum[31]) begin
          sat_s = 1'b1;
          res_s = sum[32] ? WORD_MIN : WORD_MAX;
        end else res_s = sum[31:0];
      end
      CMD_SUB: begin
        if (diff[32] != diff[31]) begin
          sat_s = 1'b1;
          res_s = diff[32] ? WORD_MIN : WORD_MAX;
        end else res_s = diff[31:0];
      end
      CMD_MIN:      res_s = cmp_s.lt ? in_req.operand_a : in_req.operand_b;
      CMD_MAX:      res_s = cmp_s.gt ? in_req.operand_a : in_req.operand_b;
      CMD_INC:      res_s = in_req.operand_a + 32'sd1;
      CMD_DEC:      res_s = in_req.operand_a - 32'sd1;
      CMD_TO_INT:   res_s = in_req.operand_a >>> FRAC_BITS;
      CMD_FROM_INT: res_s = in_req.operand_a << FRAC_BITS;
      default:      res_s = '0;
    endcase
  end

  assign smag = sign_mag(pneg4, m4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1  <= in_req.cmd;
      a1    <= in_req.operand_a;
      b1    <= in_req.operand_b;
      res1  <= res_s;
      sat1  <= sat_s;
      cmp1  <= cmp_s;
      maga1 <= in_req.operand_a[31] ? 32'd0 - in_req.operand_a : in_req.operand_a;
      magb1 <= in_req.operand_b[31] ? 32'd0 - in_req.operand_b : in_req.operand_b;
      neg1  <= in_req.operand_a[31] ^ in_req.operand_b[31];

      cmd2  <= cmd1;
      res2  <= res1;
      sat2  <= sat1;
      cmp2  <= cmp1;
      prod2 <= 64'(a1) * 64'(b1);
      num2  <= {32'd0, maga1} << FRAC_BITS;
      den2  <= magb1;
      neg2  <= neg1;
      bz2   <= (magb1 == '0);
      ovf2  <= ((({32'd0, maga1} << FRAC_BITS) >> 32) >= {32'd0, magb1});

      cmd3  <= cmd2;
      res3  <= res2;
      sat3  <= sat2;
      cmp3  <= cmp2;
      pmag3 <= prod2[63] ? 64'd0 - prod2 : prod2;
      pneg3 <= prod2[63];
      num3  <= num2;
      den3  <= den2;
      neg3  <= neg2;
      ovf3  <= ovf2;
      bz3   <= bz2;

      cmd4  <= cmd3;
      res4  <= res3;
      sat4  <= sat3;
      cmp4  <= cmp3;
      m4    <= (pmag3 + HALF) >> FRAC_BITS;
      pneg4 <= pneg3;
      num4  <= num3;
      den4  <= den3;
      neg4  <= neg3;
      ovf4  <= ovf3;
      bz4   <= bz3;

      out_rec.cmd <= cmd4;
      out_rec.res <= (cmd4 == CMD_MUL) ? smag[31:0] : res4;
      out_rec.sat <= (cmd4 == CMD_MUL) ? smag[32] : sat4;
      out_rec.dbz <= (cmd4 == CMD_DIV) && bz4;
      out_rec.cmp <= cmp4;
      out_rec.rem <= num4[63:32];
      out_rec.low <= num4[31:0];
      out_rec.den <= den4;
      out_rec.quo <= '0;
      out_rec.neg <= neg4;
      out_rec.ovf <= ovf4;
    end
  end

endmodule

// File: design/fpa_div_step.sv
module fpa_div_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  fpa_pkg::div_rec_t in_rec,
  output logic              out_valid,
  output fpa_pkg::div_rec_t out_rec
);
  import fpa_pkg::*;

  logic [32:0] r2;
  logic        take;
  div_rec_t    rec_next;

  always_comb begin
    r2   = {in_rec.rem, in_rec.low[31]};
    take = r2 >= {1'b0, in_rec.den};
    rec_next     = in_rec;
    rec_next.rem = take ? 32'(r2 - {1'b0, in_rec.den}) : r2[31:0];
    rec_next.low = {in_rec.low[30:0], 1'b0};
    rec_next.quo = {in_rec.quo[30:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rec <= rec_next;
    end
  end

endmodule

// File: design/fpa_back.sv
module fpa_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  fpa_pkg::div_rec_t in_rec,
  output logic              out_valid,
  output fpa_pkg::alu_rsp_t out_rsp
);
  import fpa_pkg::*;

  logic [32:0] q33;
  logic [32:0] smag;
  alu_rsp_t    rsp_next;

  always_comb begin
    q33  = {1'b0, in_rec.quo} + 33'({in_rec.rem, 1'b0} >= {1'b0, in_rec.den});
    smag = sign_mag(in_rec.neg, {31'd0, q33});
    rsp_next.result          = in_rec.res;
    rsp_next.saturated       = in_rec.sat;
    rsp_next.divide_by_zero  = in_rec.dbz;
    rsp_next.a_greater       = in_rec.cmp.gt;
    rsp_next.a_less          = in_rec.cmp.lt;
    rsp_next.a_greater_equal = in_rec.cmp.ge;
    rsp_next.a_less_equal    = in_rec.cmp.le;
    rsp_next.a_equal         = in_rec.cmp.eq;
    rsp_next.a_not_equal     = in_rec.cmp.ne;
    if (in_rec.cmd == CMD_DIV) begin
      priority if (in_rec.dbz) begin
        rsp_next.result    = '0;
        rsp_next.saturated = 1'b0;
      end else if (in_rec.ovf) begin
        rsp_next.result    = in_rec.neg ? WORD_MIN : WORD_MAX;
        rsp_next.saturated = 1'b1;
      end else begin
        rsp_next.result    = smag[31:0];
        rsp_next.saturated = smag[32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rsp <= rsp_next;
    end
  end

endmodule

// File: design/fixed_point_alu.sv
// Signed fixed-point ALU, 32-bit words with FRAC_BITS fraction bits. Fully
// pipelined: one request is taken every cycle unless the output stalls, and its
// response passes 5 front stages (operand prep, 32x32 multiply, rounding), 32
// divider stages, one quotient bit each, and 1 output stage. The 32-stage
// restoring divider sets the latency. The whole pipeline advances together:
// it holds only while a response sits at the output and rsp_ready is low.
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  fpa_pkg::alu_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output fpa_pkg::alu_rsp_t rsp
);
  import fpa_pkg::*;

  logic     en;
  logic     chain_valid [DIV_STEPS+1];
  div_rec_t chain_rec   [DIV_STEPS+1];

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .in_req    (req),
    .out_valid (chain_valid[0]),
    .out_rec   (chain_rec[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fpa_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[i]),
      .in_rec    (chain_rec[i]),
      .out_valid (chain_valid[i+1]),
      .out_rec   (chain_rec[i+1])
    );
  end

  fpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[DIV_STEPS]),
    .in_rec    (chain_rec[DIV_STEPS]),
    .out_valid (rsp_valid),
    .out_rsp   (rsp)
  );

endmodule

// File: bench/alu_checker.sv
module alu_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  fpa_pkg::alu_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  fpa_pkg::alu_rsp_t rsp,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  alu_rsp_t expected_q[$];

  function automatic logic [32:0] clamp_word(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return {1'b1, WORD_MAX};
    if (v < -64'sh8000_0000) return {1'b1, WORD_MIN};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [32:0] apply_sign(input logic neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h8000_0000) return {1'b1, WORD_MIN};
      return {1'b0, 32'(64'd0 - mag)};
    end
    if (mag > 64'h7FFF_FFFF) return {1'b1, WORD_MAX};
    return {1'b0, mag[31:0]};
  endfunction

  function automatic alu_rsp_t compute_alu(input alu_req_t r);
    alu_rsp_t o;
    logic signed [63:0] a, b, p;
    logic [63:0] ma, mb, num, q, rm, half;
    logic [32:0] sr;
    a = r.operand_a;
    b = r.operand_b;
    o = '0;
    sr = '0;
    case (r.cmd)
      CMD_ADD: sr = clamp_word(a + b);
      CMD_SUB: sr = clamp_word(a - b);
      CMD_MUL: begin
        p = a * b;
        half = (64'd1 << FRAC_BITS) >> 1;
        ma = p < 0 ? 64'd0 - p : p;
        sr = apply_sign(p < 0, (ma + half) >> FRAC_BITS);
      end
      CMD_DIV: begin
        if (b == 0) o.divide_by_zero = 1'b1;
        else begin
          ma = a < 0 ? -a : a;
          mb = b < 0 ? -b : b;
          num = ma << FRAC_BITS;
          q = num / mb;
          rm = num % mb;
          if (2 * rm >= mb) q++;
          sr = apply_sign((a < 0) != (b < 0), q);
        end
      end
      CMD_MIN: sr = {1'b0, (a < b) ? r.operand_a : r.operand_b};
      CMD_MAX: sr = {1'b0, (a > b) ? r.operand_a : r.operand_b};
      CMD_INC: sr = {1'b0, r.operand_a + 32'd1};
      CMD_DEC: sr = {1'b0, r.operand_a - 32'd1};
      CMD_TO_INT: sr = {1'b0, r.operand_a >>> FRAC_BITS};
      CMD_FROM_INT: sr = {1'b0, r.operand_a << FRAC_BITS};
      default: sr = '0;
    endcase
    o.result = sr[31:0];
    o.saturated = sr[32];
    o.a_greater = a > b;
    o.a_less = a < b;
    o.a_greater_equal = a >= b;
    o.a_less_equal = a <= b;
    o.a_equal = a == b;
    o.a_not_equal = a != b;
    return o;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    alu_rsp_t e;
    if (!rst) begin
      if (req_valid && req_ready) expected_q.push_back(compute_alu(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) report("unexpected response", rsp.result, 0);
        else begin
          e = expected_q.pop_front();
          if (rsp.result !== e.result) report("result", rsp.result, e.result);
          if (rsp.a_greater !== e.a_greater) report("a_greater", rsp.a_greater, e.a_greater);
          if (rsp.a_less !== e.a_less) report("a_less", rsp.a_less, e.a_less);
          if (rsp.a_greater_equal !== e.a_greater_equal)
            report("a_greater_equal", rsp.a_greater_equal, e.a_greater_equal);
          if (rsp.a_less_equal !== e.a_less_equal)
            report("a_less_equal", rsp.a_less_equal, e.a_less_equal);
          if (rsp.a_equal !== e.a_equal) report("a_equal", rsp.a_equal, e.a_equal);
          if (rsp.a_not_equal !== e.a_not_equal)
            report("a_not_equal", rsp.a_not_equal, e.a_not_equal);
          if (rsp.divide_by_zero !== e.divide_by_zero)
            report("divide_by_zero", rsp.divide_by_zero, e.divide_by_zero);
          if (rsp.saturated !== e.saturated) report("saturated", rsp.saturated, e.saturated);
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int LATENCY = 38;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk, rst, req_valid, req_ready, rsp_valid, rsp_ready;
  alu_req_t req;
  alu_rsp_t rsp;
  int errors, pending, idle_cycles;
  bit quiet;

  fixed_point_alu u_top (.*);
  alu_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // response side stalls in bursts
  initial begin
    int n;
    rsp_ready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!quiet && $urandom_range(3) == 0) begin
        n = $urandom_range(1, 10);
        rsp_ready <= 0;
        repeat (n) @(posedge clk);
      end
      rsp_ready <= 1;
      @(posedge clk);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return 32'($urandom_range(0, 2047)) - 32'd1024;
      3: return 32'($urandom_range(0, 3)) << $urandom_range(0, 31);
      4: return {{16{1'b0}}, 16'($urandom)} ^ {32{1'($urandom_range(1))}};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input logic [3:0] c, input logic [31:0] a, input logic [31:0] b);
    alu_req_t r;
    r.cmd = c;
    r.operand_a = a;
    r.operand_b = b;
    req <= r;
    req_valid <= 1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(4) == 0) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    logic [3:0] c;
    logic [31:0] a, b;
    int waited;
    rst = 1;
    req_valid = 0;
    req = '0;
    quiet = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, each operation, divide by zero, ties, unused codes
    send_req(CMD_ADD, WORD_MAX, 32'd1);
    send_req(CMD_ADD, WORD_MIN, WORD_MIN);
    send_req(CMD_SUB, WORD_MIN, 32'd1);
    send_req(CMD_SUB, WORD_MAX, 32'hFFFF_FFFF);
    send_req(CMD_MUL, WORD_MAX, WORD_MAX);
    send_req(CMD_MUL, WORD_MIN, WORD_MIN);
    send_req(CMD_MUL, 32'h0000_0180, 32'hFFFF_FF80);
    send_req(CMD_MUL, 32'd1, 32'd128);
    send_req(CMD_DIV, 32'd100, 32'd0);
    send_req(CMD_DIV, WORD_MIN, 32'hFFFF_FFFF);
    send_req(CMD_DIV, 32'd1, 32'd512);
    send_req(CMD_DIV, 32'hFFFF_FF00, 32'd3);
    send_req(CMD_MIN, WORD_MIN, WORD_MAX);
    send_req(CMD_MAX, WORD_MIN, WORD_MAX);
    send_req(CMD_MIN, 32'd5, 32'd5);
    send_req(CMD_INC, WORD_MAX, 32'd0);
    send_req(CMD_DEC, WORD_MIN, 32'd0);
    send_req(CMD_TO_INT, 32'hFFFF_FF01, 32'd0);
    send_req(CMD_TO_INT, WORD_MAX, WORD_MIN);
    send_req(CMD_FROM_INT, WORD_MAX, 32'd0);
    send_req(CMD_FROM_INT, 32'hFFFF_FFFF, 32'd1);
    send_req(4'd10, 32'd1, 32'd2);
    send_req(4'd15, WORD_MAX, WORD_MAX);
    req_valid <= 0;

    // hold off until the pipeline has drained
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 650; i++) begin
      if (i == 560) quiet = 1;
      c = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      a = pick_word();
      b = ($urandom_range(9) == 0) ? 32'd0 : ($urandom_range(7) == 0 ? a : pick_word());
      send_req(c, a, b);
      maybe_gap();
    end
    req_valid <= 0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

// File: filelist.f
design/fpa_pkg.sv
design/fpa_front.sv
design/fpa_div_step.sv
design/fpa_back.sv
design/fixed_point_alu.sv
bench/alu_checker.sv
bench/tb.sv
